// ----- rtl/rsti_pkg.sv -----
package rsti_pkg;

  // Field widths fixed by the interface.
  localparam int CHAR_W  = 8;
  localparam int RADIX_W = 5;
  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;

  // Character codes and radix limits.
  localparam logic [CHAR_W-1:0]  CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0]  CHAR_UPPER_F = 8'h46;
  localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;

  // Decoded digit: ok is low for any character that is not a digit.
  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] val;
  } digit_t;

  // One converted result.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      error;
  } result_t;

  // Maps '0'-'9' to 0..9 and 'A'-'F' to 10..15.
  function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
    digit_t d;
    logic [CHAR_W-1:0] ofs;
    d   = '0;
    ofs = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      ofs   = c - CHAR_ZERO;
      d.ok  = 1'b1;
      d.val = ofs[DIGIT_W-1:0];
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      ofs   = c - CHAR_UPPER_A + 8'd10;
      d.ok  = 1'b1;
      d.val = ofs[DIGIT_W-1:0];
    end
    return d;
  endfunction

endpackage

// ----- rtl/rsti_char_if.sv -----
interface rsti_char_if import rsti_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ----- rtl/rsti_result_if.sv -----
interface rsti_result_if import rsti_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

// ----- rtl/radix_string_to_int32_top.sv -----
// Streaming string-to-integer converter. Each char_in transaction carries one
// ASCII character, most significant first, and is_last marks the end of the
// string. An optional leading '-' negates; digits are '0'-'9' and 'A'-'F' and
// must be below the radix held in the configuration register (reset 10, written
// through cfg_wr_en and cfg_wr_data; the user must do so only while no string is in
// flight, unenforced by the block). Each string yields one result_out transaction
// after its final character: the value sign-extended from RESULT_BITS to 32 bits,
// and error, which flags a bad character, a digit not below the radix, a radix above
// 16, or overflow; the value is zero whenever error is set. One character is accepted
// every cycle unless a final one meets a full result register that is not read. The
// clock period is set by the multiply-add of the magnitude by the radix and its limit
// compare, which sit between the input register and the result register.
module radix_string_to_int32_top import rsti_pkg::*; #(
  parameter int RESULT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  rsti_char_if.sink          char_in,
  rsti_result_if.source      result_out
);

  logic [RADIX_W-1:0] radix;

  logic               in_valid;
  logic [CHAR_W-1:0]  in_char;
  logic               in_last;
  logic               in_advance;

  logic               out_valid;
  result_t            out_result;
  result_t            step_result;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  // A held character moves on unless it is final and a full result slot is not read.
  assign in_advance    = in_valid && (!in_last || !out_valid || result_out.ready);
  assign char_in.ready = !in_valid || in_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (char_in.ready) begin
      in_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready && char_in.valid) begin
      in_char <= char_in.char_code;
      in_last <= char_in.is_last;
    end
  end

  rsti_accum #(
    .RESULT_BITS (RESULT_BITS)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .step      (in_advance),
    .char_code (in_char),
    .is_last   (in_last),
    .radix     (radix),
    .result    (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_advance && in_last) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_last) begin
      out_result <= step_result;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.value = out_result.value;
  assign result_out.error = out_result.error;

endmodule

// ----- rtl/rsti_accum.sv -----
module rsti_accum import rsti_pkg::*; #(
  parameter int RESULT_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic               is_last,
  input  logic [RADIX_W-1:0] radix,
  output result_t            result
);

  localparam int MAG_W  = RESULT_BITS;
  localparam int WIDE_W = RESULT_BITS + RADIX_W;
  localparam logic [MAG_W-1:0] HALF = {1'b1, {(MAG_W-1){1'b0}}};

  logic [MAG_W-1:0]  magnitude;
  logic              negative;
  logic              at_start;
  logic              failed;

  logic [MAG_W-1:0]  magnitude_next;
  logic              negative_next;
  logic              failed_next;

  digit_t            dig;
  logic              is_sign;
  logic              bad_digit;
  logic [MAG_W-1:0]  lim;
  logic [WIDE_W-1:0] acc;
  logic [VALUE_W-1:0] mag_ext;

  // Digit decode, range checks and the multiply-add by the radix.
  always_comb begin
    dig       = digit_of(char_code);
    is_sign   = at_start && (char_code == CHAR_MINUS);
    bad_digit = !dig.ok || (radix > RADIX_MAX) || ({1'b0, dig.val} >= radix);
    lim       = negative ? HALF : HALF - 1'b1;
    acc       = WIDE_W'(magnitude) * WIDE_W'(radix) + WIDE_W'(dig.val);

    magnitude_next = magnitude;
    negative_next  = negative;
    failed_next    = failed;
    if (is_sign) begin
      negative_next = 1'b1;
    end else if (bad_digit) begin
      failed_next = 1'b1;
    end else if (acc > WIDE_W'(lim)) begin
      // Saturate at the range limit for the sign.
      magnitude_next = lim;
      failed_next    = 1'b1;
    end else begin
      magnitude_next = acc[MAG_W-1:0];
    end
  end

  // Result for a final character; the value is forced to zero on error.
  always_comb begin
    mag_ext      = VALUE_W'(magnitude_next);
    result.error = failed_next;
    if (failed_next) begin
      result.value = '0;
    end else if (negative_next) begin
      result.value = -mag_ext;
    end else begin
      result.value = mag_ext;
    end
  end

  // String state; a final character clears it for the next string.
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude <= '0;
      negative  <= 1'b0;
      at_start  <= 1'b1;
      failed    <= 1'b0;
    end else if (step) begin
      if (is_last) begin
        magnitude <= '0;
        negative  <= 1'b0;
        at_start  <= 1'b1;
        failed    <= 1'b0;
      end else begin
        magnitude <= magnitude_next;
        negative  <= negative_next;
        at_start  <= 1'b0;
        failed    <= failed_next;
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rsti_pkg::*;

  localparam int RESULT_BITS = 32;
  // A generous bound on the length of the whole run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 300;
  // A result passes the input and result registers; this drain covers the pipeline.
  localparam int DRAIN_CYCLES = 8;

  // Character codes used to build malformed strings.
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_G = 8'h47;

  // Tracks the converter state and holds the expected results in order.
  class conv_scoreboard;
    logic [RADIX_W-1:0] radix;
    logic [32:0]        magnitude;
    bit                 negative;
    bit                 at_start;
    bit                 failed;
    result_t            expected_q[$];
    int                 mismatches;

    function new();
      radix      = RADIX_RESET;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      magnitude = '0;
      negative  = 1'b0;
      at_start  = 1'b1;
      failed    = 1'b0;
    endfunction

    // Advances the state by one accepted character transaction.
    function void note_char(logic [CHAR_W-1:0] c, logic last);
      logic [63:0] lim;
      logic [63:0] next;
      logic [63:0] signed_val;
      logic [4:0]  dval;
      bit          is_digit;
      bit          first;
      result_t     res;
      dval     = '0;
      is_digit = 1'b1;
      first    = at_start;
      at_start = 1'b0;
      if (first && c == CHAR_MINUS) begin
        negative = 1'b1;
      end else begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          dval = 5'(c - CHAR_ZERO);
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
          dval = 5'(c - CHAR_UPPER_A + 8'd10);
        end else begin
          is_digit = 1'b0;
        end
        if (!is_digit || radix > RADIX_MAX || dval >= radix) begin
          failed = 1'b1;
        end else begin
          // A negative string may reach one step further than a positive one.
          lim  = (64'd1 << (RESULT_BITS - 1)) - (negative ? 64'd0 : 64'd1);
          next = magnitude * radix + dval;
          if (next > lim) begin
            magnitude = lim[32:0];
            failed    = 1'b1;
          end else begin
            magnitude = next[32:0];
          end
        end
      end
      if (last) begin
        signed_val = negative ? (64'd0 - magnitude) : {31'd0, magnitude};
        res.value  = failed ? '0 : signed_val[VALUE_W-1:0];
        res.error  = failed;
        expected_q.push_back(res);
        clear_string();
      end
    endfunction

    // Compares one result transaction against the oldest expectation.
    task check_result(logic signed [VALUE_W-1:0] v, logic e);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value %0d error %0b", v, e));
        return;
      end
      want = expected_q.pop_front();
      if (v !== want.value)
        report($sformatf("value %0d, expected %0d", v, want.value));
      if (e !== want.error)
        report($sformatf("error %0b, expected %0b", e, want.error));
    endtask

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [RADIX_W-1:0] cfg_wr_data;
  bit                 steady;
  bit                 hold;
  int                 accepted_chars;
  int                 cycle_count;
  logic [CHAR_W-1:0]  str_q[$];

  conv_scoreboard sb = new();

  rsti_char_if   char_if();
  rsti_result_if res_if();

  radix_string_to_int32_top #(.RESULT_BITS(RESULT_BITS)) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .char_in    (char_if),
    .result_out (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one character and waits for its transaction to complete.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    while (!steady && $urandom_range(99) < 30) begin
      char_if.valid <= 1'b0;
      @(posedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= c;
    char_if.is_last   <= last;
    @(posedge clk);
    while (!char_if.ready) @(posedge clk);
    sb.note_char(c, last);
    accepted_chars++;
  endtask

  // Sends the built string, flagging its final character.
  task automatic send_string();
    foreach (str_q[i]) send_char(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    send_string();
  endtask

  // Writes the radix once every result is out and the pipeline has drained.
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    char_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.radix = r;
  endtask

  function automatic logic [CHAR_W-1:0] digit_char(input int d);
    return (d < 10) ? CHAR_W'(CHAR_ZERO + d) : CHAR_W'(CHAR_UPPER_A + (d - 10));
  endfunction

  // Writes a magnitude in the given radix, with an optional sign and up to two leading zeros.
  function automatic void build_value(input logic [63:0] mag, input bit neg,
                                      input logic [RADIX_W-1:0] r);
    logic [CHAR_W-1:0] digits[$];
    int                zeros;
    if (neg) str_q.push_back(CHAR_MINUS);
    zeros = $urandom_range(2);
    repeat (zeros) str_q.push_back(CHAR_ZERO);
    do begin
      digits.push_front(digit_char(int'(mag % r)));
      mag = mag / r;
    end while (mag != 0);
    foreach (digits[i]) str_q.push_back(digits[i]);
  endfunction

  // Builds one random string: mostly well-formed, some near the range limits,
  // some with a corrupted character, and some plain noise.
  function automatic void build_string(input logic [RADIX_W-1:0] r);
    int         kind;
    int         len;
    int         pos;
    logic [3:0] top_digit;
    bit         usable;
    usable = (r >= 2 && r <= RADIX_MAX);
    kind   = $urandom_range(99);
    str_q.delete();
    if (kind < 15 && usable) begin
      build_value(64'h8000_0000 + $urandom_range(4) - 3, $urandom_range(1) == 1, r);
    end else if (kind < 85) begin
      if ($urandom_range(99) < 40) str_q.push_back(CHAR_MINUS);
      len       = $urandom_range(1, (r <= 3) ? 34 : 12);
      top_digit = usable ? 4'(r - 1'b1) : 4'd15;
      repeat (len) begin
        if (r <= 1 && $urandom_range(99) < 70) str_q.push_back(CHAR_ZERO);
        else str_q.push_back(digit_char($urandom_range(top_digit)));
      end
      if (kind >= 70) begin
        pos = $urandom_range(str_q.size() - 1);
        case ($urandom_range(3))
          0: str_q[pos] = CHAR_W'($urandom_range(255));
          1: str_q[pos] = CHAR_MINUS;
          2: str_q[pos] = CHAR_LOWER_A + CHAR_W'($urandom_range(5));
          default: str_q[pos] = CHAR_UPPER_G;
        endcase
      end
    end else begin
      if ($urandom_range(99) < 30) str_q.push_back(CHAR_MINUS);
      len = $urandom_range(1, 5);
      repeat (len) str_q.push_back(CHAR_W'($urandom_range(255)));
    end
  endfunction

  // Result side: checks each completed transaction and stalls at random.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready)
        sb.check_result(res_if.value, res_if.error);
      res_if.ready <= !hold && (steady || $urandom_range(99) >= 30);
    end
  end

  // One long receiver hold-off while characters keep coming.
  initial begin
    hold <= 1'b0;
    wait (accepted_chars >= HOLD_AFTER);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // Main sequence: reset, directed strings, then random phases per radix.
  initial begin
    logic [RADIX_W-1:0] plan[$];
    int                 budget;
    int                 used;
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    char_if.valid     <= 1'b0;
    char_if.char_code <= '0;
    char_if.is_last   <= 1'b0;
    steady            <= 1'b0;
    accepted_chars    = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sign handling, misplaced minus and characters outside the digit set.
    set_radix(RADIX_RESET);
    send_text("-");
    send_text("--");
    send_text("1-");
    send_text("G");
    send_text("a");
    send_text("9");
    // Radix zero rejects every digit; radix one takes only zero.
    set_radix(5'd0);
    send_text("0");
    set_radix(5'd1);
    send_text("0");
    send_text("01");
    // A radix above sixteen fails on any digit but not on a lone sign.
    set_radix(5'd17);
    send_text("5");
    set_radix(5'd31);
    send_text("-");
    // Top digit in base sixteen and the extreme character codes.
    set_radix(RADIX_MAX);
    send_text("F");
    send_text("-F");
    str_q = '{8'h00, 8'hFF};
    send_string();

    plan = '{5'd10, 5'd16, 5'd2};
    repeat (3) plan.push_back(RADIX_W'($urandom_range(2, 16)));
    plan.push_back(5'd1);
    plan.push_back(5'd0);
    plan.push_back(5'd31);
    plan.push_back(5'd17);
    foreach (plan[p]) begin
      set_radix(plan[p]);
      // The base-sixteen phase runs with no idling on either side.
      steady <= (p == 1);
      budget = (plan[p] >= 2 && plan[p] <= RADIX_MAX) ? 130 : 40;
      used   = 0;
      while (used < budget) begin
        build_string(plan[p]);
        used += str_q.size();
        send_string();
      end
    end
    steady <= 1'b0;

    // Drain the remaining results.
    char_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0) sb.report("results still outstanding");
    if (sb.mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// ----- radix_string_to_int32_top.f -----
rtl/rsti_pkg.sv
rtl/rsti_char_if.sv
rtl/rsti_result_if.sv
rtl/rsti_accum.sv
rtl/radix_string_to_int32_top.sv
bench/tb.sv
